// ===== src/gbnfec_pkg.sv =====
package gbnfec_pkg;

  // Fixed field widths of the block's ports.
  localparam int PORT_OFF_W = 24;
  localparam int SIZE_W     = 16;
  localparam int WIN_W      = 8;
  localparam int CNT16_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEG_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECV_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEC_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES = 2'd3;

  // Configuration reset values.
  localparam logic [SIZE_W-1:0]     RST_SEG_PAYLOAD = 16'd1024;
  localparam logic [WIN_W-1:0]      RST_RECV_WINDOW = 8'd8;
  localparam logic [WIN_W-1:0]      RST_FEC_WINDOW  = 8'd4;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_BYTES = 24'd0;

  // Event codes of an input item.
  typedef enum logic [1:0] {
    OP_ROUND_START = 2'd0,
    OP_SEND_SLOT   = 2'd1,
    OP_ACK         = 2'd2,
    OP_TIMEOUT     = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_DIV,
    ST_CHECK,
    ST_APPLY,
    ST_POST_LOAD,
    ST_POST_DIV,
    ST_FINISH
  } state_t;

endpackage

// ===== src/go_back_n_sender_window_fec_top.sv =====
// Go-Back-N sender window control with FEC grouping.
// Input channel (in_valid/in_ready) carries one event per transfer: round_start,
// send_slot, ack or timeout, with the drop flags and the ack offset. Every event
// gives exactly one result transfer on the output channel (out_valid/out_ready):
// the segment and FEC packet produced, if any, and the window status afterwards.
// Configuration registers are written through cfg_valid/cfg_ready with a register
// index and data; cfg_ready is always high, and writes are to be made only while
// idle, which the block itself does not enforce. The window test divides the
// outstanding bytes by the segment payload with one shared restoring divider
// that yields one quotient bit per cycle. A send_slot runs the divider twice
// (before and after the state update); the other events run it once. One event
// is in work at a time; in_ready is low while it runs, and the next event can
// be taken in the cycle after the result moves to the output register. The
// result waits in the output register, so a new event can be accepted
// meanwhile; when the receiver stalls, the sequencer holds its finished result
// until it is free.
// Synchronous active-low reset clears the window state and round counts and
// restores the configuration defaults.
module go_back_n_sender_window_fec_top #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_op,
  input  logic                                 in_seg_drop,
  input  logic                                 in_fec_drop,
  input  logic [gbnfec_pkg::PORT_OFF_W-1:0]    in_ack_offset,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_seg_valid,
  output logic [gbnfec_pkg::PORT_OFF_W-1:0]    out_seg_offset,
  output logic [gbnfec_pkg::SIZE_W-1:0]        out_seg_size,
  output logic                                 out_seg_dropped,
  output logic                                 out_fec_emit,
  output logic                                 out_fec_dropped,
  output logic [gbnfec_pkg::PORT_OFF_W-1:0]    out_fec_offset,
  output logic [gbnfec_pkg::WIN_W-1:0]         out_fec_group_size,
  output logic                                 out_window_open,
  output logic                                 out_all_acked,
  output logic [gbnfec_pkg::PORT_OFF_W-1:0]    out_unacked_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gbnfec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbnfec_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int OB    = OFFSET_BITS;
  localparam int CNT_W = $clog2(OFFSET_BITS + 1);
  localparam int CW    = OFFSET_BITS + 2;
  localparam int SW    = gbnfec_pkg::SIZE_W;
  localparam int WW    = gbnfec_pkg::WIN_W;
  localparam int PW    = gbnfec_pkg::PORT_OFF_W;
  localparam int RW    = gbnfec_pkg::CNT16_W;

  // Configuration registers.
  logic [SW-1:0] seg_payload_r;
  logic [WW-1:0] recv_window_r;
  logic [WW-1:0] fec_window_r;
  logic [OB-1:0] image_r;

  // Window state.
  logic [OB-1:0] next_r;
  logic [OB-1:0] unacked_r;
  logic [WW-1:0] fec_cnt_r;
  logic [RW-1:0] round_drops_r;
  logic [RW-1:0] round_fecs_r;

  // Captured event.
  gbnfec_pkg::op_t op_r;
  logic            seg_drop_r;
  logic            fec_drop_r;
  logic [OB-1:0]   ack_r;

  // Shared divider: quotient shifts in where the dividend shifts out.
  logic [OB-1:0]    quo_r;
  logic [SW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;

  // Sequencer.
  gbnfec_pkg::state_t state_r, state_nxt;
  logic send_ok_r;
  logic [SW-1:0] size_r;

  // Result of the event, waiting for the final window status.
  logic          res_seg_valid_r;
  logic [PW-1:0] res_seg_offset_r;
  logic [SW-1:0] res_seg_size_r;
  logic          res_seg_dropped_r;
  logic          res_fec_emit_r;
  logic          res_fec_dropped_r;
  logic [PW-1:0] res_fec_offset_r;
  logic [WW-1:0] res_fec_group_size_r;

  // Output register.
  logic          out_valid_r;
  logic          out_seg_valid_r;
  logic [PW-1:0] out_seg_offset_r;
  logic [SW-1:0] out_seg_size_r;
  logic          out_seg_dropped_r;
  logic          out_fec_emit_r;
  logic          out_fec_dropped_r;
  logic [PW-1:0] out_fec_offset_r;
  logic [WW-1:0] out_fec_group_size_r;
  logic          out_window_open_r;
  logic          out_all_acked_r;
  logic [PW-1:0] out_unacked_r;

  // Control decoded from the state.
  logic div_load, div_run, check_en, apply_en, finish_en;

  // Datapath signals.
  logic [SW-1:0] pl_eff;
  logic [OB-1:0] outstanding;
  logic [SW:0]   div_shift;
  logic [SW:0]   div_diff;
  logic          div_fit;
  logic [CW-1:0] need;
  logic [CW-1:0] gain;
  logic          usable;
  logic          data_left;
  logic [OB-1:0] left;
  logic [WW-1:0] fec_inc;
  logic [OB-1:0] next_adv;
  logic          fec_close;
  logic          in_acc;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // A zero payload acts as one byte.
  assign pl_eff = (seg_payload_r == '0) ? SW'(1) : seg_payload_r;

  // Bytes in flight; zero once an ack has passed the send point.
  assign outstanding = (next_r > unacked_r) ? (next_r - unacked_r) : '0;

  // One restoring division step.
  assign div_shift = {rem_r, quo_r[OB-1]};
  assign div_diff  = div_shift - {1'b0, pl_eff};
  assign div_fit   = (div_shift >= {1'b0, pl_eff});

  // The window is usable when quotient + round_fecs + 1 < recv_window + round_drops.
  assign need      = CW'(quo_r) + CW'(round_fecs_r) + CW'(1);
  assign gain      = CW'(recv_window_r) + CW'(round_drops_r);
  assign usable    = (need < gain);
  assign data_left = (next_r < image_r);
  assign left      = image_r - next_r;

  // Segment bookkeeping for a send.
  assign fec_inc   = (fec_cnt_r == '1) ? fec_cnt_r : (fec_cnt_r + WW'(1));
  assign next_adv  = next_r + OB'(size_r);
  assign fec_close = ((fec_window_r != '0) && (fec_inc == fec_window_r)) ||
                     (next_adv == image_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbnfec_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (gbnfec_pkg::op_t'(in_op) == gbnfec_pkg::OP_SEND_SLOT) begin
            state_nxt = gbnfec_pkg::ST_PRE_DIV;
          end else begin
            state_nxt = gbnfec_pkg::ST_APPLY;
          end
        end
      end
      gbnfec_pkg::ST_PRE_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = gbnfec_pkg::ST_CHECK;
        end
      end
      gbnfec_pkg::ST_CHECK:     state_nxt = gbnfec_pkg::ST_APPLY;
      gbnfec_pkg::ST_APPLY:     state_nxt = gbnfec_pkg::ST_POST_LOAD;
      gbnfec_pkg::ST_POST_LOAD: state_nxt = gbnfec_pkg::ST_POST_DIV;
      gbnfec_pkg::ST_POST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = gbnfec_pkg::ST_FINISH;
        end
      end
      gbnfec_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = gbnfec_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbnfec_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    div_load  = 1'b0;
    div_run   = 1'b0;
    check_en  = 1'b0;
    apply_en  = 1'b0;
    finish_en = 1'b0;
    case (state_r)
      gbnfec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        div_load = in_valid;
      end
      gbnfec_pkg::ST_PRE_DIV:   div_run   = (cnt_r != '0);
      gbnfec_pkg::ST_CHECK:     check_en  = 1'b1;
      gbnfec_pkg::ST_APPLY:     apply_en  = 1'b1;
      gbnfec_pkg::ST_POST_LOAD: div_load  = 1'b1;
      gbnfec_pkg::ST_POST_DIV:  div_run   = (cnt_r != '0);
      gbnfec_pkg::ST_FINISH:    finish_en = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbnfec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_payload_r <= gbnfec_pkg::RST_SEG_PAYLOAD;
      recv_window_r <= gbnfec_pkg::RST_RECV_WINDOW;
      fec_window_r  <= gbnfec_pkg::RST_FEC_WINDOW;
      image_r       <= OB'(32'(gbnfec_pkg::RST_IMAGE_BYTES));
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbnfec_pkg::REG_SEG_PAYLOAD: seg_payload_r <= cfg_data[SW-1:0];
        gbnfec_pkg::REG_RECV_WINDOW: recv_window_r <= cfg_data[WW-1:0];
        gbnfec_pkg::REG_FEC_WINDOW:  fec_window_r  <= cfg_data[WW-1:0];
        gbnfec_pkg::REG_IMAGE_BYTES: image_r       <= OB'(32'(cfg_data));
        default: begin
        end
      endcase
    end
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= gbnfec_pkg::op_t'(in_op);
      seg_drop_r <= in_seg_drop;
      fec_drop_r <= in_fec_drop;
      ack_r      <= OB'(32'(in_ack_offset));
    end
  end

  // Shared divider: outstanding / payload, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (div_load) begin
      cnt_r <= CNT_W'(OFFSET_BITS);
    end else if (div_run) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      quo_r <= outstanding;
      rem_r <= '0;
    end else if (div_run) begin
      quo_r <= {quo_r[OB-2:0], div_fit};
      rem_r <= div_fit ? div_diff[SW-1:0] : div_shift[SW-1:0];
    end
  end

  // Send decision and segment size, taken from the state before the event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_ok_r <= 1'b0;
    end else if (check_en) begin
      send_ok_r <= usable && data_left;
    end
  end

  always_ff @(posedge clk) begin
    if (check_en) begin
      size_r <= (OB'(pl_eff) < left) ? pl_eff : left[SW-1:0];
    end
  end

  // Window state update for each event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r        <= '0;
      unacked_r     <= '0;
      fec_cnt_r     <= '0;
      round_drops_r <= '0;
      round_fecs_r  <= '0;
    end else if (apply_en) begin
      case (op_r)
        gbnfec_pkg::OP_ROUND_START: begin
          round_drops_r <= '0;
          round_fecs_r  <= '0;
        end
        gbnfec_pkg::OP_SEND_SLOT: begin
          if (send_ok_r) begin
            next_r    <= next_adv;
            fec_cnt_r <= fec_close ? '0 : fec_inc;
            if (seg_drop_r && (round_drops_r != '1)) begin
              round_drops_r <= round_drops_r + RW'(1);
            end
            if (fec_close && !fec_drop_r && (round_fecs_r != '1)) begin
              round_fecs_r <= round_fecs_r + RW'(1);
            end
          end
        end
        gbnfec_pkg::OP_ACK: begin
          if (ack_r > unacked_r) begin
            unacked_r <= ack_r;
          end
        end
        gbnfec_pkg::OP_TIMEOUT: begin
          next_r    <= unacked_r;
          fec_cnt_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Segment and FEC fields of the result; zero when nothing was produced.
  always_ff @(posedge clk) begin
    if (apply_en) begin
      res_seg_valid_r      <= 1'b0;
      res_seg_offset_r     <= '0;
      res_seg_size_r       <= '0;
      res_seg_dropped_r    <= 1'b0;
      res_fec_emit_r       <= 1'b0;
      res_fec_dropped_r    <= 1'b0;
      res_fec_offset_r     <= '0;
      res_fec_group_size_r <= '0;
      if ((op_r == gbnfec_pkg::OP_SEND_SLOT) && send_ok_r) begin
        res_seg_valid_r   <= 1'b1;
        res_seg_offset_r  <= PW'(32'(next_r));
        res_seg_size_r    <= size_r;
        res_seg_dropped_r <= seg_drop_r;
        if (fec_close) begin
          res_fec_emit_r       <= 1'b1;
          res_fec_dropped_r    <= fec_drop_r;
          res_fec_offset_r     <= PW'(32'(next_adv));
          res_fec_group_size_r <= fec_inc;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en) begin
      out_seg_valid_r      <= res_seg_valid_r;
      out_seg_offset_r     <= res_seg_offset_r;
      out_seg_size_r       <= res_seg_size_r;
      out_seg_dropped_r    <= res_seg_dropped_r;
      out_fec_emit_r       <= res_fec_emit_r;
      out_fec_dropped_r    <= res_fec_dropped_r;
      out_fec_offset_r     <= res_fec_offset_r;
      out_fec_group_size_r <= res_fec_group_size_r;
      out_window_open_r    <= usable && data_left;
      out_all_acked_r      <= (unacked_r >= image_r);
      out_unacked_r        <= PW'(32'(unacked_r));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seg_valid      = out_seg_valid_r;
  assign out_seg_offset     = out_seg_offset_r;
  assign out_seg_size       = out_seg_size_r;
  assign out_seg_dropped    = out_seg_dropped_r;
  assign out_fec_emit       = out_fec_emit_r;
  assign out_fec_dropped    = out_fec_dropped_r;
  assign out_fec_offset     = out_fec_offset_r;
  assign out_fec_group_size = out_fec_group_size_r;
  assign out_window_open    = out_window_open_r;
  assign out_all_acked      = out_all_acked_r;
  assign out_unacked_out    = out_unacked_r;

  // An accepted event keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  // An FEC packet is only reported together with a segment.
  a_fec_needs_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fec_emit |-> out_seg_valid)
    else $error("FEC packet reported without a segment");

  // A result without a segment carries zero segment fields.
  a_no_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_seg_valid |-> (out_seg_size == '0) && !out_seg_dropped)
    else $error("segment fields set without a segment");

  // The second division always ends in the finishing state.
  a_div_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbnfec_pkg::ST_POST_DIV) && (cnt_r == '0) |=>
      (state_r == gbnfec_pkg::ST_FINISH))
    else $error("sequencer skipped the finishing state");

  // A produced segment is never empty.
  a_seg_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seg_valid |-> (out_seg_size != '0))
    else $error("segment of zero bytes");

endmodule

// ===== tb/go_back_n_sender_window_fec_top_tb.sv =====
module go_back_n_sender_window_fec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_W     = gbnfec_pkg::SIZE_W;
  localparam int WIN_W      = gbnfec_pkg::WIN_W;
  localparam int PORT_OFF_W = gbnfec_pkg::PORT_OFF_W;
  localparam int CNT16_W    = gbnfec_pkg::CNT16_W;
  localparam int CFG_IDX_W  = gbnfec_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = gbnfec_pkg::CFG_DATA_W;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 600;
  localparam int END_SETTLE     = 80;

  // Window controller state and configuration as the checker tracks them.
  typedef struct packed {
    logic [SIZE_W-1:0]     payload;
    logic [WIN_W-1:0]      rwin;
    logic [WIN_W-1:0]      fwin;
    logic [PORT_OFF_W-1:0] img;
    logic [PORT_OFF_W-1:0] next_off;
    logic [PORT_OFF_W-1:0] unacked;
    logic [WIN_W-1:0]      grp;
    logic [CNT16_W-1:0]    drops;
    logic [CNT16_W-1:0]    fecs;
  } win_state_t;

  typedef struct packed {
    gbnfec_pkg::op_t       op;
    logic                  seg_drop;
    logic                  fec_drop;
    logic [PORT_OFF_W-1:0] ack;
  } win_event_t;

  typedef struct packed {
    logic                  seg_valid;
    logic [PORT_OFF_W-1:0] seg_offset;
    logic [SIZE_W-1:0]     seg_size;
    logic                  seg_dropped;
    logic                  fec_emit;
    logic                  fec_dropped;
    logic [PORT_OFF_W-1:0] fec_offset;
    logic [WIN_W-1:0]      fec_group_size;
    logic                  window_open;
    logic                  all_acked;
    logic [PORT_OFF_W-1:0] unacked_out;
  } send_result_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_op = 2'd0;
  logic                  in_seg_drop = 1'b0;
  logic                  in_fec_drop = 1'b0;
  logic [PORT_OFF_W-1:0] in_ack_offset = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_seg_valid;
  logic [PORT_OFF_W-1:0] out_seg_offset;
  logic [SIZE_W-1:0]     out_seg_size;
  logic                  out_seg_dropped;
  logic                  out_fec_emit;
  logic                  out_fec_dropped;
  logic [PORT_OFF_W-1:0] out_fec_offset;
  logic [WIN_W-1:0]      out_fec_group_size;
  logic                  out_window_open;
  logic                  out_all_acked;
  logic [PORT_OFF_W-1:0] out_unacked_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  go_back_n_sender_window_fec_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_seg_drop        (in_seg_drop),
    .in_fec_drop        (in_fec_drop),
    .in_ack_offset      (in_ack_offset),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_seg_valid      (out_seg_valid),
    .out_seg_offset     (out_seg_offset),
    .out_seg_size       (out_seg_size),
    .out_seg_dropped    (out_seg_dropped),
    .out_fec_emit       (out_fec_emit),
    .out_fec_dropped    (out_fec_dropped),
    .out_fec_offset     (out_fec_offset),
    .out_fec_group_size (out_fec_group_size),
    .out_window_open    (out_window_open),
    .out_all_acked      (out_all_acked),
    .out_unacked_out    (out_unacked_out),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // dut_model follows accepted transfers; plan_model runs ahead as events are queued.
  win_state_t   dut_model;
  win_state_t   plan_model;
  win_event_t   pending_events[$];
  send_result_t expected_results[$];
  int unsigned  events_open = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  stray_results = 0;
  int unsigned  idle_cycles = 0;
  logic         in_fire = 1'b0;

  function automatic win_state_t reset_state();
    win_state_t s;
    s = '0;
    s.payload = gbnfec_pkg::RST_SEG_PAYLOAD;
    s.rwin    = gbnfec_pkg::RST_RECV_WINDOW;
    s.fwin    = gbnfec_pkg::RST_FEC_WINDOW;
    s.img     = gbnfec_pkg::RST_IMAGE_BYTES[PORT_OFF_W-1:0];
    return s;
  endfunction

  function automatic void set_reg(inout win_state_t s, input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    case (idx)
      gbnfec_pkg::REG_SEG_PAYLOAD: s.payload = data[SIZE_W-1:0];
      gbnfec_pkg::REG_RECV_WINDOW: s.rwin = data[WIN_W-1:0];
      gbnfec_pkg::REG_FEC_WINDOW:  s.fwin = data[WIN_W-1:0];
      gbnfec_pkg::REG_IMAGE_BYTES: s.img = data[PORT_OFF_W-1:0];
      default: ;
    endcase
  endfunction

  // A zero payload counts as one byte per segment.
  function automatic logic [SIZE_W-1:0] eff_payload(win_state_t s);
    return (s.payload == '0) ? SIZE_W'(1) : s.payload;
  endfunction

  // Window test: the receiver window plus drops must exceed the segments in flight,
  // the FEC packets sent and one, and some data must be left.
  function automatic bit send_allowed(win_state_t s);
    longint outst;
    longint gain;
    longint cost;
    outst = (s.next_off > s.unacked) ? longint'(s.next_off) - longint'(s.unacked) : 0;
    gain  = longint'(s.rwin) + longint'(s.drops);
    cost  = outst / longint'(eff_payload(s)) + longint'(s.fecs) + 1;
    return (gain > cost) && (s.next_off < s.img);
  endfunction

  // Applies one event to the window state and returns the result it produces.
  function automatic send_result_t gbn_advance(inout win_state_t s, input win_event_t e);
    send_result_t r;
    logic [PORT_OFF_W-1:0] left;
    logic [SIZE_W-1:0] pl;
    logic [SIZE_W-1:0] size;
    r = '0;
    case (e.op)
      gbnfec_pkg::OP_ROUND_START: begin
        s.drops = '0;
        s.fecs  = '0;
      end
      gbnfec_pkg::OP_SEND_SLOT: begin
        if (send_allowed(s)) begin
          left = s.img - s.next_off;
          pl   = eff_payload(s);
          size = (PORT_OFF_W'(pl) < left) ? pl : left[SIZE_W-1:0];
          r.seg_valid   = 1'b1;
          r.seg_offset  = s.next_off;
          r.seg_size    = size;
          r.seg_dropped = e.seg_drop;
          if (s.grp != '1) s.grp = s.grp + WIN_W'(1);
          if (e.seg_drop && s.drops != '1) s.drops = s.drops + CNT16_W'(1);
          s.next_off = s.next_off + PORT_OFF_W'(size);
          // The group closes when it is full or the last byte went out.
          if ((s.fwin != '0 && s.grp == s.fwin) || s.next_off == s.img) begin
            r.fec_emit       = 1'b1;
            r.fec_dropped    = e.fec_drop;
            r.fec_offset     = s.next_off;
            r.fec_group_size = s.grp;
            if (!e.fec_drop && s.fecs != '1) s.fecs = s.fecs + CNT16_W'(1);
            s.grp = '0;
          end
        end
      end
      gbnfec_pkg::OP_ACK: begin
        if (e.ack > s.unacked) s.unacked = e.ack;
      end
      gbnfec_pkg::OP_TIMEOUT: begin
        s.next_off = s.unacked;
        s.grp      = '0;
      end
      default: ;
    endcase
    r.window_open = send_allowed(s);
    r.all_acked   = (s.unacked >= s.img);
    r.unacked_out = s.unacked;
    return r;
  endfunction

  // Sender: takes items from the pending queue in bursts separated by gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    win_event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        ev = pending_events.pop_front();
        in_valid      <= 1'b1;
        in_op         <= ev.op;
        in_seg_drop   <= ev.seg_drop;
        in_fec_drop   <= ev.fec_drop;
        in_ack_offset <= ev.ack;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input transfers: predict the result of every accepted event.
  always @(posedge clk) begin
    win_event_t ev;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      ev.op       = gbnfec_pkg::op_t'(in_op);
      ev.seg_drop = in_seg_drop;
      ev.fec_drop = in_fec_drop;
      ev.ack      = in_ack_offset;
      expected_results.push_back(gbn_advance(dut_model, ev));
    end
  end

  // Receiver: switches between stall patterns, with one long hold while events wait.
  rx_mode_t    rx_mode = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic [7:0]  stall_pattern = 8'hFF;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 330 && pending_events.size() >= 10) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left  = $urandom_range(20, 150);
        stall_pattern = 8'($urandom_range(1, 255));
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 60);
        default: begin
          out_ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10)
        $display("result %0d field %s: expected 0x%0h, got 0x%0h", results_seen, name,
                 want, got);
    end
  endfunction

  // Output transfers: compare each result with the oldest prediction.
  always @(posedge clk) begin
    send_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen = results_seen + 1;
      if (expected_results.size() == 0) begin
        stray_results = stray_results + 1;
        $display("result %0d arrived with no event waiting for it", results_seen);
      end else begin
        want = expected_results.pop_front();
        events_open = events_open - 1;
        check_field("seg_valid", 32'(out_seg_valid), 32'(want.seg_valid));
        check_field("seg_offset", 32'(out_seg_offset), 32'(want.seg_offset));
        check_field("seg_size", 32'(out_seg_size), 32'(want.seg_size));
        check_field("seg_dropped", 32'(out_seg_dropped), 32'(want.seg_dropped));
        check_field("fec_emit", 32'(out_fec_emit), 32'(want.fec_emit));
        check_field("fec_dropped", 32'(out_fec_dropped), 32'(want.fec_dropped));
        check_field("fec_offset", 32'(out_fec_offset), 32'(want.fec_offset));
        check_field("fec_group_size", 32'(out_fec_group_size),
                    32'(want.fec_group_size));
        check_field("window_open", 32'(out_window_open), 32'(want.window_open));
        check_field("all_acked", 32'(out_all_acked), 32'(want.all_acked));
        check_field("unacked_out", 32'(out_unacked_out), 32'(want.unacked_out));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_event(gbnfec_pkg::op_t op, logic sd, logic fd,
                            logic [PORT_OFF_W-1:0] ack);
    win_event_t ev;
    send_result_t unused;
    ev.op       = op;
    ev.seg_drop = sd;
    ev.fec_drop = fd;
    ev.ack      = ack;
    pending_events.push_back(ev);
    unused = gbn_advance(plan_model, ev);
    events_open = events_open + 1;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_reg(dut_model, idx, data);
    set_reg(plan_model, idx, data);
  endtask

  task automatic program_window(logic [SIZE_W-1:0] pl, logic [WIN_W-1:0] rw,
                                logic [WIN_W-1:0] fw, logic [PORT_OFF_W-1:0] img);
    write_reg(gbnfec_pkg::REG_SEG_PAYLOAD, CFG_DATA_W'(pl));
    write_reg(gbnfec_pkg::REG_RECV_WINDOW, CFG_DATA_W'(rw));
    write_reg(gbnfec_pkg::REG_FEC_WINDOW, CFG_DATA_W'(fw));
    write_reg(gbnfec_pkg::REG_IMAGE_BYTES, CFG_DATA_W'(img));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The block is idle once every queued event has returned its result.
  task automatic wait_drained();
    while (events_open != 0) @(negedge clk);
  endtask

  function automatic int unsigned transfer_base();
    return (plan_model.next_off > plan_model.unacked) ? 32'(plan_model.next_off)
                                                      : 32'(plan_model.unacked);
  endfunction

  // New window settings with a fresh amount of data beyond what was already sent.
  task automatic pick_random_window();
    logic [SIZE_W-1:0] pl;
    logic [WIN_W-1:0] rw;
    logic [WIN_W-1:0] fw;
    int unsigned amount;
    int unsigned img;
    case ($urandom_range(0, 5))
      0: pl = SIZE_W'(1);
      1: pl = '1;
      2, 3: pl = SIZE_W'($urandom_range(1, 64));
      default: pl = SIZE_W'($urandom_range(65, 3000));
    endcase
    case ($urandom_range(0, 9))
      0: rw = '0;
      1: rw = '1;
      2: rw = WIN_W'(1);
      default: rw = WIN_W'($urandom_range(2, 16));
    endcase
    case ($urandom_range(0, 7))
      0: fw = '0;
      1: fw = WIN_W'(1);
      2: fw = '1;
      default: fw = WIN_W'($urandom_range(2, 8));
    endcase
    amount = 32'(pl) * $urandom_range(1, 30) + $urandom_range(0, 32'(pl) - 1);
    img = transfer_base() + amount;
    if (img > 24'hFFFFFF) img = 24'hFFFFFF;
    program_window(pl, rw, fw, img[PORT_OFF_W-1:0]);
  endtask

  // Mostly sends and acks near the window edges, some rewinds and stray acks.
  task automatic add_random_event();
    int unsigned pick;
    logic [PORT_OFF_W-1:0] lo;
    logic [PORT_OFF_W-1:0] hi;
    logic [PORT_OFF_W-1:0] a;
    pick = $urandom_range(0, 99);
    a    = PORT_OFF_W'($urandom());
    lo   = plan_model.unacked;
    hi   = plan_model.next_off;
    if (pick < 8) begin
      push_event(gbnfec_pkg::OP_ROUND_START, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), a);
    end else if (pick < 60) begin
      push_event(gbnfec_pkg::OP_SEND_SLOT, ($urandom_range(0, 3) == 0),
                 ($urandom_range(0, 2) == 0), a);
    end else if (pick < 88) begin
      if ($urandom_range(0, 19) == 0) begin
        a = PORT_OFF_W'($urandom_range(0, 32'(plan_model.img)));
      end else if (hi <= lo) begin
        a = lo;
      end else begin
        case ($urandom_range(0, 3))
          0: a = hi;
          3: a = PORT_OFF_W'($urandom_range(0, 32'(lo)));
          default: a = lo + PORT_OFF_W'($urandom_range(0, 32'(hi - lo)));
        endcase
      end
      push_event(gbnfec_pkg::OP_ACK, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), a);
    end else begin
      push_event(gbnfec_pkg::OP_TIMEOUT, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), a);
    end
  endtask

  // Test sequence.
  initial begin
    int unsigned random_done;
    int unsigned n;
    int unsigned base;
    dut_model  = reset_state();
    plan_model = dut_model;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: nothing to send yet.
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_TIMEOUT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ROUND_START, 1'b0, 1'b0, '0);
    wait_drained();

    // Small transfer: FEC drop, closed window, short last segment, stale and full acks.
    program_window(16'd300, 8'd3, 8'd2, 24'd1000);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b1, 1'b1, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, 24'd600);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, 24'd500);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, 24'd1000);
    push_event(gbnfec_pkg::OP_ROUND_START, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_TIMEOUT, 1'b0, 1'b0, '0);
    wait_drained();

    // Zero payload acts as one byte; zero FEC window closes only at the last byte.
    base = transfer_base();
    program_window(16'd0, 8'd2, 8'd0, PORT_OFF_W'(base + 3));
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, PORT_OFF_W'(base + 1));
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b1, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, PORT_OFF_W'(base + 2));
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b1, '0);
    wait_drained();

    // Long group without a FEC window so the group count saturates.
    base = transfer_base();
    program_window(16'd1, 8'hFF, 8'd0, PORT_OFF_W'(base + 300));
    for (int k = 0; k < 300; k++) begin
      push_event(gbnfec_pkg::OP_SEND_SLOT, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), PORT_OFF_W'($urandom()));
      if (k % 40 == 39) push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, plan_model.next_off);
    end
    wait_drained();

    // Random phases, each with its own settings.
    random_done = 0;
    while (random_done < 500) begin
      pick_random_window();
      n = $urandom_range(40, 110);
      for (int k = 0; k < n; k++) begin
        add_random_event();
        random_done = random_done + 1;
        if (plan_model.unacked >= plan_model.img) break;
      end
      wait_drained();
    end

    // Largest settings, then an ack of all ones beyond the next offset and equal to the image.
    program_window('1, '1, '1, 24'hFFFFFF);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b1, 1'b0, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b1, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b0, 1'b0, plan_model.next_off);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_ACK, 1'b1, 1'b1, 24'hFFFFFF);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_TIMEOUT, 1'b0, 1'b0, '0);
    push_event(gbnfec_pkg::OP_SEND_SLOT, 1'b1, 1'b1, '0);
    push_event(gbnfec_pkg::OP_ROUND_START, 1'b1, 1'b1, 24'hFFFFFF);
    wait_drained();

    repeat (END_SETTLE) @(negedge clk);
    if (mismatches == 0 && stray_results == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
